/* hw/rtl/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants of the dense shortest path block
// Request and result layouts, configuration register map, command codes.
// ----------------------------------------------------------------------------
package dsp_pkg;

   // Fixed field widths
   localparam int NODE_BITS   = 4;
   localparam int COUNT_BITS  = 5;
   localparam int WFIELD_BITS = 16;
   localparam int DIST_BITS   = 20;

   // Saturated distance, also reported for unreachable nodes
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(16);
   localparam logic [NODE_BITS-1:0]  START_NODE_RESET = '0;

   typedef enum logic {
      REG_NODE_COUNT = 1'b0,
      REG_START_NODE = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_RUN   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                command;
      logic [NODE_BITS-1:0]   row;
      logic [NODE_BITS-1:0]   col;
      logic [WFIELD_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] node;
      logic [DIST_BITS-1:0] distance;
      logic                 unreachable;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] node_count;
      logic [NODE_BITS-1:0]  start_node;
   } cfg_type;

endpackage

/* hw/rtl/dsp_ram.sv */
// ----------------------------------------------------------------------------
// dsp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module dsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/dsp_csr.sv */
// ----------------------------------------------------------------------------
// dsp_csr: configuration registers
// APB-style access to node count and start node, zero wait states.
// ----------------------------------------------------------------------------
module dsp_csr
   import dsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [COUNT_BITS-1:0] node_count_ff;
   logic [NODE_BITS-1:0]  start_node_ff;
   reg_index_type         reg_sel;
   logic                  wr_en;

   // Word select ignores the byte offset
   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_en   = psel & penable & pwrite & pready;
   assign pready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         start_node_ff <= START_NODE_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_NODE_COUNT: node_count_ff <= pwdata[COUNT_BITS-1:0];
            REG_START_NODE: start_node_ff <= pwdata[NODE_BITS-1:0];
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_sel)
         REG_NODE_COUNT: prdata = CSR_DATA_BITS'(node_count_ff);
         REG_START_NODE: prdata = CSR_DATA_BITS'(start_node_ff);
      endcase
   end

   assign cfg.node_count = node_count_ff;
   assign cfg.start_node = start_node_ff;

endmodule

/* hw/rtl/dsp_engine.sv */
// ----------------------------------------------------------------------------
// dsp_engine: request handling and search sequencer
// Stores edge weights, runs the shortest path search over the weight and
// distance memories, and streams one result per node.
// ----------------------------------------------------------------------------
module dsp_engine
   import dsp_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16,
   parameter int OUT_LIMIT   = (MAX_NODES < 16) ? MAX_NODES : 16,
   parameter int STORE_BITS  = (WEIGHT_BITS < WFIELD_BITS) ? WEIGHT_BITS : WFIELD_BITS,
   parameter int WT_AW       = $clog2(MAX_NODES * MAX_NODES),
   parameter int DIST_AW     = $clog2(OUT_LIMIT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   // weight memory
   output logic                  wt_we,
   output logic [WT_AW-1:0]      wt_waddr,
   output logic [STORE_BITS-1:0] wt_wdata,
   output logic [WT_AW-1:0]      wt_raddr,
   input  logic [STORE_BITS-1:0] wt_rdata,
   // distance memory
   output logic                  dist_we,
   output logic [DIST_AW-1:0]    dist_waddr,
   output logic [DIST_BITS-1:0]  dist_wdata,
   output logic [DIST_AW-1:0]    dist_raddr,
   input  logic [DIST_BITS-1:0]  dist_rdata
);

   localparam logic [COUNT_BITS-1:0] LIMIT       = COUNT_BITS'(OUT_LIMIT);
   localparam logic [WT_AW-1:0]      ROW_STRIDE  = WT_AW'(MAX_NODES);
   localparam bit                    HAS_NO_EDGE = (WEIGHT_BITS <= WFIELD_BITS);

   typedef enum logic [2:0] {
      IDLE,
      INIT,
      PICK,
      RELAX,
      EMIT_RD,
      EMIT_LD,
      EMIT_WAIT
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic [NODE_BITS-1:0]  src_ff;
   logic                  valid_src_ff;
   logic                  pend_ff;
   logic [DIST_AW-1:0]    pend_idx_ff;
   logic [OUT_LIMIT-1:0]  done_ff;
   logic [OUT_LIMIT-1:0]  reach_ff;
   logic                  found_ff;
   logic [DIST_AW-1:0]    pick_ff;
   logic [DIST_BITS-1:0]  best_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [COUNT_BITS-1:0] n_in;
   logic                  valid_src_in;
   logic                  found_in;
   logic [DIST_AW-1:0]    pick_in;
   logic [DIST_BITS-1:0]  best_in;

   logic                  run_accept;
   logic                  scan_issue;
   logic [DIST_AW-1:0]    cnt_idx;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [DIST_AW-1:0]    base_idx;
   logic                  no_edge;
   logic                  init_wb;
   logic                  relax_wb;
   logic                  eligible;
   logic [DIST_BITS:0]    path_sum;
   logic [DIST_BITS-1:0]  cand;
   logic                  relax_upd;
   logic                  rsp_take;
   logic                  emit_next;
   logic                  reach_out;

   // Clamp the node count and check the source
   always_comb begin
      if (cfg.node_count == '0) begin
         n_in = COUNT_BITS'(1);
      end else if (cfg.node_count > LIMIT) begin
         n_in = LIMIT;
      end else begin
         n_in = cfg.node_count;
      end
      valid_src_in = COUNT_BITS'(cfg.start_node) < n_in;
   end

   assign req_stall  = (state_ff != IDLE);
   assign run_accept = req_valid && !req_stall && (req_payload.command == CMD_RUN);

   // Scan counter and memory addressing
   assign scan_issue = ((state_ff == INIT) || (state_ff == PICK) || (state_ff == RELAX))
                       && (cnt_ff < n_ff);
   assign cnt_idx    = cnt_ff[DIST_AW-1:0];
   assign cnt_inc    = cnt_ff + COUNT_BITS'(1);
   assign base_idx   = (state_ff == RELAX) ? pick_ff : src_ff[DIST_AW-1:0];
   assign wt_raddr   = WT_AW'(base_idx) * ROW_STRIDE + WT_AW'(cnt_idx);

   // Edge weight writes
   assign wt_we    = req_valid && !req_stall && (req_payload.command == CMD_WRITE)
                     && (req_payload.row < MAX_NODES) && (req_payload.col < MAX_NODES);
   assign wt_waddr = WT_AW'(req_payload.row) * ROW_STRIDE + WT_AW'(req_payload.col);
   assign wt_wdata = req_payload.weight[STORE_BITS-1:0];

   assign no_edge  = HAS_NO_EDGE && (wt_rdata == {STORE_BITS{1'b1}});
   assign init_wb  = pend_ff && (state_ff == INIT);
   assign relax_wb = pend_ff && (state_ff == RELAX);

   // Minimum search: strict compare keeps the lowest index on ties
   assign eligible = pend_ff && (state_ff == PICK) && !done_ff[pend_idx_ff]
                     && reach_ff[pend_idx_ff] && (!found_ff || (dist_rdata < best_ff));
   assign found_in = found_ff || eligible;
   assign pick_in  = eligible ? pend_idx_ff : pick_ff;
   assign best_in  = eligible ? dist_rdata : best_ff;

   // Relaxation with saturating path sum
   assign path_sum  = {1'b0, best_ff} + (DIST_BITS + 1)'(wt_rdata);
   assign cand      = path_sum[DIST_BITS] ? DIST_MAX : path_sum[DIST_BITS-1:0];
   assign relax_upd = relax_wb && !done_ff[pend_idx_ff] && !no_edge
                      && (!reach_ff[pend_idx_ff] || (cand < dist_rdata));

   // Distance memory access
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign emit_next  = (state_ff == EMIT_WAIT) && rsp_take && !rsp_ff.last;
   assign dist_raddr = emit_next ? cnt_inc[DIST_AW-1:0] : cnt_idx;
   assign dist_we    = init_wb || relax_upd;
   assign dist_waddr = pend_idx_ff;

   always_comb begin
      if (relax_wb) begin
         dist_wdata = cand;
      end else if ((pend_idx_ff == src_ff[DIST_AW-1:0]) || no_edge) begin
         dist_wdata = '0;
      end else begin
         dist_wdata = DIST_BITS'(wt_rdata);
      end
   end

   assign reach_out = valid_src_ff && reach_ff[cnt_idx];

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         done_ff      <= '0;
         reach_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff     <= scan_issue;
         pend_idx_ff <= cnt_idx;

         // Seed distances from the source row
         if (init_wb) begin
            if (pend_idx_ff == src_ff[DIST_AW-1:0]) begin
               reach_ff[pend_idx_ff] <= 1'b1;
               done_ff[pend_idx_ff]  <= 1'b1;
            end else begin
               reach_ff[pend_idx_ff] <= !no_edge;
               done_ff[pend_idx_ff]  <= 1'b0;
            end
         end

         // Mark improved nodes reachable
         if (relax_upd) begin
            reach_ff[pend_idx_ff] <= 1'b1;
         end

         unique case (state_ff)
            IDLE: begin
               if (run_accept) begin
                  n_ff         <= n_in;
                  src_ff       <= cfg.start_node;
                  valid_src_ff <= valid_src_in;
                  cnt_ff       <= '0;
                  state_ff     <= valid_src_in ? INIT : EMIT_RD;
               end
            end
            INIT: begin
               if (cnt_ff < n_ff) begin
                  cnt_ff <= cnt_inc;
               end else begin
                  cnt_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= PICK;
               end
            end
            PICK: begin
               found_ff <= found_in;
               pick_ff  <= pick_in;
               best_ff  <= best_in;
               if (cnt_ff < n_ff) begin
                  cnt_ff <= cnt_inc;
               end else begin
                  cnt_ff <= '0;
                  if (found_in) begin
                     done_ff[pick_in] <= 1'b1;
                     state_ff         <= RELAX;
                  end else begin
                     state_ff <= EMIT_RD;
                  end
               end
            end
            RELAX: begin
               if (cnt_ff < n_ff) begin
                  cnt_ff <= cnt_inc;
               end else begin
                  cnt_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= PICK;
               end
            end
            EMIT_RD: begin
               state_ff <= EMIT_LD;
            end
            EMIT_LD: begin
               rsp_ff.node        <= NODE_BITS'(cnt_ff);
               rsp_ff.distance    <= reach_out ? dist_rdata : DIST_MAX;
               rsp_ff.unreachable <= !reach_out;
               rsp_ff.last        <= (cnt_inc == n_ff);
               rsp_valid_ff       <= 1'b1;
               state_ff           <= EMIT_WAIT;
            end
            EMIT_WAIT: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_ff.last) begin
                     state_ff <= IDLE;
                  end else begin
                     cnt_ff   <= cnt_inc;
                     state_ff <= EMIT_LD;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/dense_shortest_path.sv */
// ----------------------------------------------------------------------------
// dense_shortest_path: single-source shortest paths over a weight matrix
// Write requests fill the edge weight memory; a run request searches from
// the configured start node and returns one distance per node.
//
//   channel   direction   handshake                payload
//   req_*     in          req_valid / req_stall    req_type (command,row,col,weight)
//   rsp_*     out         rsp_valid / rsp_stall    rsp_type (node,distance,flags)
//   csr       in/out      psel/penable/pready      node_count, start_node
//
// Weight write requests stream back to back while no run is in progress.
// A run request with a valid start node seeds the distances from its row,
// then for each picked node runs a minimum search and a relaxation pass,
// plus one last search that finds no node left, each scanning through the
// single read port of each memory; after a read state each result is loaded
// and held until taken. No request is taken from run acceptance until the
// last result is taken. A stall on rsp holds the current result. Reset
// clears control state only; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module dense_shortest_path
   import dsp_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int OUT_LIMIT  = (MAX_NODES < 16) ? MAX_NODES : 16;
   localparam int STORE_BITS = (WEIGHT_BITS < WFIELD_BITS) ? WEIGHT_BITS : WFIELD_BITS;
   localparam int WT_DEPTH   = MAX_NODES * MAX_NODES;
   localparam int WT_AW      = $clog2(WT_DEPTH);
   localparam int DIST_AW    = $clog2(OUT_LIMIT);

   cfg_type               cfg;
   logic                  wt_we;
   logic [WT_AW-1:0]      wt_waddr;
   logic [STORE_BITS-1:0] wt_wdata;
   logic [WT_AW-1:0]      wt_raddr;
   logic [STORE_BITS-1:0] wt_rdata;
   logic                  dist_we;
   logic [DIST_AW-1:0]    dist_waddr;
   logic [DIST_BITS-1:0]  dist_wdata;
   logic [DIST_AW-1:0]    dist_raddr;
   logic [DIST_BITS-1:0]  dist_rdata;

   // Configuration registers
   dsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Edge weight memory
   dsp_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (WT_DEPTH)
   ) u_weight_ram (
      .clock (clock),
      .we    (wt_we),
      .waddr (wt_waddr),
      .wdata (wt_wdata),
      .raddr (wt_raddr),
      .rdata (wt_rdata)
   );

   // Best distance memory
   dsp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (OUT_LIMIT)
   ) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .raddr (dist_raddr),
      .rdata (dist_rdata)
   );

   // Search sequencer
   dsp_engine #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .OUT_LIMIT   (OUT_LIMIT),
      .STORE_BITS  (STORE_BITS),
      .WT_AW       (WT_AW),
      .DIST_AW     (DIST_AW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .wt_we       (wt_we),
      .wt_waddr    (wt_waddr),
      .wt_wdata    (wt_wdata),
      .wt_raddr    (wt_raddr),
      .wt_rdata    (wt_rdata),
      .dist_we     (dist_we),
      .dist_waddr  (dist_waddr),
      .dist_wdata  (dist_wdata),
      .dist_raddr  (dist_raddr),
      .dist_rdata  (dist_rdata)
   );

endmodule
